// ===== rtl/core/stp_pkg.sv =====
package stp_pkg;

  localparam int PERIOD_BITS_DEF = 16;
  localparam int DIV_BITS        = 32;
  localparam int DIV_CNT_W       = $clog2(DIV_BITS);
  localparam int PERIOD_W        = 16;
  localparam int SEL_W           = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 2;

  localparam logic OP_PLAN   = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  localparam logic ST_OK         = 1'b0;
  localparam logic ST_NEG_BUDGET = 1'b1;

  localparam logic [SEL_W-1:0] CS_OFF  = 3'd0;
  localparam logic [SEL_W-1:0] CS_DIV1 = 3'd1;
  localparam logic [SEL_W-1:0] CS_DIV2 = 3'd2;
  localparam logic [SEL_W-1:0] CS_DIV4 = 3'd3;
  localparam logic [SEL_W-1:0] CS_DIV8 = 3'd4;

  localparam logic [1:0] PWR_OFF    = 2'd0;
  localparam logic [1:0] PWR_ALWAYS = 2'd1;
  localparam logic [1:0] PWR_CYCLE  = 2'd2;
  localparam logic [1:0] PWR_MOVING = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIR_POLARITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWR_SEL      = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bypass;
    logic mag_zero;
  } dp_stat_t;

endpackage

// ===== rtl/core/stp_ctrl.sv =====
module stp_ctrl
  import stp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt  = '0;
        if (stat.bypass || stat.mag_zero) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_BITS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

// ===== rtl/core/stp_dpath.sv =====
module stp_dpath
  import stp_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_op,
  input  logic signed [31:0]    in_clock_budget,
  input  logic signed [31:0]    in_target_steps,
  input  logic signed [31:0]    in_correction,
  output logic [SEL_W-1:0]      out_clock_select,
  output logic [PERIOD_W-1:0]   out_period,
  output logic                  out_dir_out,
  output logic                  out_reverse,
  output logic                  out_energize_req,
  output logic                  out_status
);

  localparam int PW = PERIOD_BITS;
  localparam int XW = DIV_BITS + 4;

  logic                pol_r;
  logic [1:0]          mode_r;
  logic [DIV_BITS-1:0] cur_pos_r;
  logic                tie_r;

  logic                op_r;
  logic [DIV_BITS-1:0] clocks_r, target_r, corr_r;
  logic [DIV_BITS-1:0] mag_r, rem_r, quot_r;
  logic                neg_r;

  logic [DIV_BITS-1:0] travel, mag;
  logic [DIV_BITS-1:0] sh;
  logic [DIV_BITS:0]   diff;

  logic [XW-1:0]       qx;
  logic                fit0, fit1, fit2, fit3;
  logic [SEL_W-1:0]    sel, sel_fin;
  logic [PW-1:0]       base, per_fin;
  logic                tie_hit, above, round_ok, inc;
  logic [31:0]         per_ext;
  logic                energize;

  // travel and its magnitude
  always_comb begin
    travel = target_r - cur_pos_r + corr_r;
    mag    = travel[DIV_BITS-1] ? (DIV_BITS'(0) - travel) : travel;
  end

  assign stat.bypass   = (op_r == OP_PRESET) || clocks_r[DIV_BITS-1];
  assign stat.mag_zero = (mag == '0);

  // one restoring division step
  always_comb begin
    sh   = {rem_r[DIV_BITS-2:0], quot_r[DIV_BITS-1]};
    diff = {1'b0, sh} - {1'b0, mag_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_op;
      clocks_r <= in_clock_budget;
      target_r <= in_target_steps;
      corr_r   <= in_correction;
    end
    if (cmd.prep) begin
      mag_r  <= mag;
      neg_r  <= travel[DIV_BITS-1];
      rem_r  <= '0;
      quot_r <= (mag == '0) ? '0 : clocks_r;
    end else if (cmd.div_step) begin
      if (!diff[DIV_BITS]) begin
        rem_r  <= diff[DIV_BITS-1:0];
        quot_r <= {quot_r[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= sh;
        quot_r <= {quot_r[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  // prescaler, period, rounding and energize request
  always_comb begin
    qx   = XW'(quot_r);
    fit0 = (qx >> PW) == '0;
    fit1 = (qx >> (PW + 1)) == '0;
    fit2 = (qx >> (PW + 2)) == '0;
    fit3 = (qx >> (PW + 3)) == '0;
    if (fit0) begin
      sel = CS_DIV1;
    end else if (fit1) begin
      sel = CS_DIV2;
    end else if (fit2) begin
      sel = CS_DIV4;
    end else if (fit3) begin
      sel = CS_DIV8;
    end else begin
      sel = CS_OFF;
    end

    case (sel)
      CS_DIV2: begin
        base    = PW'(quot_r >> 1);
        tie_hit = quot_r[0];
        above   = 1'b0;
      end
      CS_DIV4: begin
        base    = PW'(quot_r >> 2);
        tie_hit = quot_r[1] && !quot_r[0];
        above   = quot_r[1] && quot_r[0];
      end
      CS_DIV8: begin
        base    = PW'(quot_r >> 3);
        tie_hit = quot_r[2] && (quot_r[1:0] == 2'b00);
        above   = quot_r[2] && (quot_r[1:0] != 2'b00);
      end
      default: begin
        base    = PW'(quot_r);
        tie_hit = 1'b0;
        above   = 1'b0;
      end
    endcase

    round_ok = (sel == CS_DIV2 || sel == CS_DIV4 || sel == CS_DIV8) &&
               (base != {PW{1'b1}});
    inc      = round_ok && (above || (tie_hit && tie_r));
    per_fin  = base + PW'(inc);
    sel_fin  = (sel == CS_OFF || per_fin == '0) ? CS_OFF : sel;
    per_ext  = (sel_fin == CS_OFF) ? 32'd0 : 32'(per_fin);

    case (mode_r) inside
      PWR_ALWAYS, PWR_CYCLE: energize = 1'b1;
      PWR_MOVING:            energize = (sel_fin != CS_OFF);
      default:               energize = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (op_r == OP_PRESET) begin
        out_clock_select <= CS_OFF;
        out_period       <= '0;
        out_dir_out      <= 1'b0;
        out_reverse      <= 1'b0;
        out_energize_req <= 1'b0;
        out_status       <= ST_OK;
      end else if (clocks_r[DIV_BITS-1]) begin
        out_clock_select <= CS_OFF;
        out_period       <= '0;
        out_dir_out      <= 1'b0;
        out_reverse      <= 1'b0;
        out_energize_req <= 1'b0;
        out_status       <= ST_NEG_BUDGET;
      end else begin
        out_clock_select <= sel_fin;
        out_period       <= per_ext[PERIOD_W-1:0];
        out_dir_out      <= neg_r ^ pol_r;
        out_reverse      <= neg_r;
        out_energize_req <= energize;
        out_status       <= ST_OK;
      end
    end
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r     <= 1'b0;
      mode_r    <= PWR_ALWAYS;
      cur_pos_r <= '0;
      tie_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIR_POLARITY: pol_r  <= cfg_data[0];
          CFG_PWR_SEL:      mode_r <= cfg_data;
          default:          ;
        endcase
      end
      if (cmd.prep && !(op_r == OP_PLAN && clocks_r[DIV_BITS-1])) begin
        cur_pos_r <= target_r;
      end
      if (cmd.load && !stat.bypass && round_ok && tie_hit) begin
        tie_r <= !tie_r;
      end
    end
  end

endmodule

// ===== rtl/core/step_timer_planner_core.sv =====
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   op, clock_budget, target_steps, correction
// out_     output     out_valid / out_stall clock_select, period, dir_out, reverse,
//                                           energize_req, status
// cfg_     input      cfg_we                cfg_index, cfg_data
//
// A result is loaded after acceptance once travel, 32 steps of the bit-serial divider,
// then prescaler and rounding are done and the output register is free; the next item
// is taken only after that load. Presets, negative budgets and zero travel skip the divider.
// Synchronous active-low reset: position 0, polarity 0, power mode 1.
// A waiting result does not block the next item; only loading a new result
// waits for the output register to drain.
module step_timer_planner_core
  import stp_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic signed [31:0]    in_clock_budget,
  input  logic signed [31:0]    in_target_steps,
  input  logic signed [31:0]    in_correction,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SEL_W-1:0]      out_clock_select,
  output logic [PERIOD_W-1:0]   out_period,
  output logic                  out_dir_out,
  output logic                  out_reverse,
  output logic                  out_energize_req,
  output logic                  out_status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  stp_dpath #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_clock_budget  (in_clock_budget),
    .in_target_steps  (in_target_steps),
    .in_correction    (in_correction),
    .out_clock_select (out_clock_select),
    .out_period       (out_period),
    .out_dir_out      (out_dir_out),
    .out_reverse      (out_reverse),
    .out_energize_req (out_energize_req),
    .out_status       (out_status)
  );

`ifndef SYNTHESIS
  a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_valid && out_stall))
    else $error("result loaded over a waiting item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after acceptance");

  a_neg_budget_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NEG_BUDGET) |->
      (out_clock_select == CS_OFF && out_period == '0 && !out_energize_req))
    else $error("negative budget result not cleared");

  a_off_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clock_select == CS_OFF) |-> out_period == '0)
    else $error("period non-zero with clock off");
`endif

endmodule

// ===== bench/tb_step_timer_planner_core.sv =====
module tb_step_timer_planner_core
  import stp_pkg::*;
();

  localparam int PMAX = (1 << PERIOD_W) - 1;

  typedef struct packed {
    logic [SEL_W-1:0]    sel;
    logic [PERIOD_W-1:0] period;
    logic                dir;
    logic                rev;
    logic                energize;
    logic                status;
  } plan_t;

  class timer_plan_board;
    logic        polarity;
    logic [1:0]  pwr_sel;
    logic [31:0] position;
    logic        tie_up;
    plan_t       planned_results[$];
    int          mismatches;

    function new();
      polarity   = 1'b0;
      pwr_sel    = PWR_ALWAYS;
      position   = '0;
      tie_up     = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return planned_results.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DIR_POLARITY) polarity = data[0];
      else if (idx == CFG_PWR_SEL) pwr_sel = data;
    endfunction

    function void note_item(logic op, logic [31:0] budget, logic [31:0] target,
                            logic [31:0] corr);
      plan_t       r;
      logic [31:0] travel, mag, ticks, period, dropped, half;
      logic        neg;
      logic [SEL_W-1:0] sel;
      int          shift;
      r = '0;
      if (op == OP_PRESET) begin
        position = target;
      end else if (budget[31]) begin
        r.status = ST_NEG_BUDGET;
      end else begin
        travel = target - position + corr;
        neg = travel[31];
        mag = neg ? (32'd0 - travel) : travel;
        ticks = (mag != 0) ? budget / mag : 32'd0;
        position = target;
        if (ticks <= PMAX) sel = CS_DIV1;
        else if (ticks <= 2 * PMAX + 1) sel = CS_DIV2;
        else if (ticks <= 4 * PMAX + 3) sel = CS_DIV4;
        else if (ticks <= 8 * PMAX + 7) sel = CS_DIV8;
        else sel = CS_OFF;
        period = '0;
        if (sel != CS_OFF) begin
          shift = sel - 1;
          period = ticks >> shift;
          if (ticks > PMAX && period < PMAX) begin
            dropped = ticks & ((32'd1 << shift) - 32'd1);
            half = 32'd1 << (shift - 1);
            if (dropped == half) begin
              if (tie_up) period = period + 1;
              tie_up = !tie_up;
            end else if (dropped > half) begin
              period = period + 1;
            end
          end
        end
        if (period == 0) sel = CS_OFF;
        if (sel == CS_OFF) period = '0;
        r.sel = sel;
        r.period = period[PERIOD_W-1:0];
        r.dir = neg ^ polarity;
        r.rev = neg;
        case (pwr_sel)
          PWR_ALWAYS, PWR_CYCLE: r.energize = 1'b1;
          PWR_MOVING: r.energize = (sel != CS_OFF);
          default: r.energize = 1'b0;
        endcase
      end
      planned_results.push_back(r);
    endfunction

    function void check_result(plan_t got);
      plan_t want;
      if (planned_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sel=%0d period=%0d dir=%0b rev=%0b en=%0b st=%0b",
                   got.sel, got.period, got.dir, got.rev, got.energize, got.status);
        return;
      end
      want = planned_results.pop_front();
      if (got.sel !== want.sel || got.period !== want.period || got.dir !== want.dir ||
          got.rev !== want.rev || got.energize !== want.energize ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected sel=%0d period=%0d dir=%0b rev=%0b en=%0b st=%0b",
                   want.sel, want.period, want.dir, want.rev, want.energize, want.status);
          $display("          actual   sel=%0d period=%0d dir=%0b rev=%0b en=%0b st=%0b",
                   got.sel, got.period, got.dir, got.rev, got.energize, got.status);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = OP_PLAN;
  logic signed [31:0]    in_clock_budget = '0;
  logic signed [31:0]    in_target_steps = '0;
  logic signed [31:0]    in_correction = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SEL_W-1:0]      out_clock_select;
  logic [PERIOD_W-1:0]   out_period;
  logic                  out_dir_out;
  logic                  out_reverse;
  logic                  out_energize_req;
  logic                  out_status;

  timer_plan_board board = new();
  logic [31:0]     pos_trk = '0;
  int              stall_mode = 0;
  int              stall_left = 0;
  int unsigned     cyc = 0;

  step_timer_planner_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_clock_budget  (in_clock_budget),
    .in_target_steps  (in_target_steps),
    .in_correction    (in_correction),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_clock_select (out_clock_select),
    .out_period       (out_period),
    .out_dir_out      (out_dir_out),
    .out_reverse      (out_reverse),
    .out_energize_req (out_energize_req),
    .out_status       (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cyc[3:2] == 2'b00);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        board.note_item(in_op, in_clock_budget, in_target_steps, in_correction);
      if (out_valid && !out_stall)
        board.check_result({out_clock_select, out_period, out_dir_out, out_reverse,
                            out_energize_req, out_status});
    end
  end

  task automatic send(input logic op, input logic [31:0] budget, input logic [31:0] target,
                      input logic [31:0] corr);
    in_valid <= 1'b1;
    in_op <= op;
    in_clock_budget <= budget;
    in_target_steps <= target;
    in_correction <= corr;
    do @(posedge clk); while (in_stall);
    if (op == OP_PRESET || !budget[31]) pos_trk = target;
  endtask

  task automatic move(input logic [31:0] budget, input logic [31:0] travel,
                      input logic [31:0] corr);
    send(OP_PLAN, budget, pos_trk + travel - corr, corr);
  endtask

  task automatic quiesce();
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic pol, input logic [1:0] mode);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIR_POLARITY;
    cfg_data <= {1'b0, pol};
    @(posedge clk);
    cfg_index <= CFG_PWR_SEL;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick, band, lo, hi, ticks, maxmag, mag, rem;
    longint      full;
    logic [31:0] travel, corr;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send(OP_PRESET, $urandom, $urandom, $urandom);
    end else if (pick < 14) begin
      send(OP_PLAN, $urandom | 32'h8000_0000, $urandom, $urandom);
    end else if (pick < 24) begin
      send(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
    end else begin
      band = $urandom_range(0, 5);
      case (band)
        0: begin lo = 1; hi = ($urandom_range(0, 1) == 0) ? 300 : PMAX; end
        1: begin lo = PMAX + 1; hi = 2 * PMAX + 1; end
        2: begin lo = 2 * PMAX + 2; hi = 4 * PMAX + 3; end
        3: begin lo = 4 * PMAX + 4; hi = 8 * PMAX + 7; end
        default: begin lo = 8 * PMAX + 8; hi = 32'h7fff_ffff; end
      endcase
      ticks = $urandom_range(lo, hi);
      if ($urandom_range(0, 2) == 0) begin
        case (band)
          1: ticks = ticks | 1;
          2: ticks = (ticks & ~32'd3) | 2;
          3: ticks = (ticks & ~32'd7) | 4;
          default: ;
        endcase
      end else if ($urandom_range(0, 5) == 0) begin
        ticks = $urandom_range(0, 1) ? lo : hi;
      end
      maxmag = 32'h7fff_ffff / ticks;
      if ($urandom_range(0, 1) == 0) mag = $urandom_range(1, (maxmag < 16) ? maxmag : 16);
      else mag = $urandom_range(1, maxmag);
      rem = $urandom_range(0, mag - 1);
      full = longint'(ticks) * longint'(mag);
      if (full + rem > 64'h7fff_ffff) rem = 32'(64'h7fff_ffff - full);
      if (band == 5) begin
        mag = 0;
        full = longint'($urandom_range(0, 32'h7fff_ffff));
        rem = 0;
      end
      travel = $urandom_range(0, 1) ? (32'd0 - mag) : mag;
      corr = $urandom_range(0, 1) ? 32'd0 : $urandom;
      move(32'(full + longint'(rem)), travel, corr);
    end
  endtask

  task automatic random_phase(input int count, input bit gaps);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < count) begin
          random_item();
          sent++;
        end
      end
      gap = (!gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    #(20 * 400000);
    $display("status: fail");
    $finish;
  end

  initial begin
    logic       pol_set[8];
    logic [1:0] mode_set[8];
    int         waited;
    pol_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    mode_set = '{PWR_OFF, PWR_MOVING, PWR_CYCLE, PWR_MOVING, PWR_OFF, PWR_ALWAYS,
                 PWR_ALWAYS, PWR_CYCLE};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    move(32'd0, 32'd0, 32'd0);
    move(32'd1000, 32'd10, 32'd0);
    send(OP_PLAN, 32'h8000_0000, 32'd5, 32'd0);
    send(OP_PRESET, 32'd0, 32'h7fff_ffff, 32'd0);
    move(32'h7fff_ffff, 32'hffff_ffff, 32'd0);
    send(OP_PRESET, 32'hffff_ffff, 32'd0, 32'hffff_ffff);
    move(32'd65535, 32'd1, 32'd0);
    move(32'd65536, 32'd1, 32'd0);
    move(32'd65537, 32'd1, 32'd0);
    move(32'd65539, 32'hffff_ffff, 32'd0);
    move(32'd131071, 32'd1, 32'd0);
    move(32'd131072, 32'd1, 32'd0);
    move(32'd131074, 32'd1, 32'd0);
    move(32'd131078, 32'd1, 32'd0);
    move(32'd131075, 32'd1, 32'd0);
    move(32'd262143, 32'd1, 32'd0);
    move(32'd262144, 32'd1, 32'd0);
    move(32'd262148, 32'd1, 32'd0);
    move(32'd524287, 32'd1, 32'd0);
    move(32'd524288, 32'd1, 32'd0);
    move(32'd1, 32'd2, 32'd0);
    move(32'h7fff_ffff, 32'hffff_fffe, 32'h7fff_ffff);
    send(OP_PLAN, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send(OP_PLAN, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    in_valid <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      quiesce();
      write_regs(pol_set[p], mode_set[p]);
      random_phase(75, (p % 3) != 2);
    end

    waited = 0;
    while (board.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (board.pending() != 0) board.mismatches++;
    if (board.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
